>>> hdl/ldrm_pkg.sv
// ----------------------------------------------------------------------------
// Letterbox dirty rectangle mapper package
// Shared word types, register indexes, geometry sequencer states and the
// restoring division step used by both the geometry unit and the item pipe.
// ----------------------------------------------------------------------------
package ldrm_pkg;

    localparam logic [2:0] REG_CLIENT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CLIENT_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BACK_WIDTH    = 3'd2;
    localparam logic [2:0] REG_BACK_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_INTEGER_MODE  = 3'd4;
    localparam logic [2:0] REG_SMOOTH_ENABLE = 3'd5;

    localparam logic [31:0] EDGE_MARK = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] rect_left;
        logic [31:0] rect_top;
        logic [31:0] rect_right;
        logic [31:0] rect_bottom;
    } in_word_t;

    typedef struct packed {
        logic        valid_res;
        logic        fallback_full;
        logic [15:0] dest_left;
        logic [15:0] dest_top;
        logic [15:0] dest_width;
        logic [15:0] dest_height;
        logic [15:0] src_left;
        logic [15:0] src_top;
        logic [15:0] src_width;
        logic [15:0] src_height;
        logic        smooth;
        logic [3:0]  band_mask;
    } out_word_t;

    typedef struct packed {
        logic [15:0] client_width;
        logic [15:0] client_height;
        logic [15:0] back_width;
        logic [15:0] back_height;
        logic        integer_mode;
        logic        smooth_enable;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] dw;
        logic [15:0] dh;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [3:0]  bands;
        logic        smooth;
    } geom_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] low;
    } div_lane_t;

    typedef enum logic [3:0] {
        GEO_IDLE,
        GEO_MUL,
        GEO_CMP,
        GEO_DIV_A,
        GEO_DIV_B,
        GEO_SCALE,
        GEO_SIZE,
        GEO_OFFSET,
        GEO_BAND
    } geo_state_t;

    // One restoring step: the partial remainder is always below the divisor,
    // so the quotient bit shifts into the vacated low end.
    function automatic div_lane_t div_step(div_lane_t a, logic [15:0] d);
        logic [16:0] t;
        div_lane_t   r;
        t     = {a.rem, a.low[15]};
        r.low = {a.low[14:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem    = 16'(t - {1'b0, d});
            r.low[0] = 1'b1;
        end
        else
        begin
            r.rem = t[15:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/letterbox_dirty_rect_mapper_core.sv
// ----------------------------------------------------------------------------
// Letterbox dirty rectangle mapper core
// Maps full presents and dirty rectangles into the aspect-fit letterbox.
// ----------------------------------------------------------------------------
// Requests arrive as words on in_data under in_valid/in_ready and results
// leave on out_data under out_valid/out_ready. Sizes and modes are written
// through cfg_write, cfg_index and cfg_data; the user must write them only
// while no word is in flight, as the core does not enforce this. Each write
// to a known register starts the geometry unit, which runs two 16-step divisions
// on its iterative divider; in_ready is low meanwhile. Writes to an unknown index
// are ignored. While the unit is idle a word is accepted every cycle unless the
// output stalls, and its result passes through clamping, the corner products,
// eight two-bit divider stages, the extent stage and the output register.
// Each stage only holds when the one after it is full and held, so a stalled
// receiver fills the pipe first; apart from geometry updates, in_ready drops
// only when it is full. Reset clears the configuration registers, the geometry
// sequencer and the valid bits; with zero sizes every result is zero.
// ----------------------------------------------------------------------------
module letterbox_dirty_rect_mapper_core #(
    parameter int COORD_BITS    = 16,
    parameter int MAX_INT_SCALE = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ldrm_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ldrm_pkg::out_word_t out_data,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import ldrm_pkg::*;

    localparam int          CB        = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam logic [15:0] SIZE_MASK = 16'((32'd1 << CB) - 32'd1);
    localparam int          NST       = 12;

    typedef struct packed {
        logic        full;
        logic        fallback;
        logic [15:0] sl;
        logic [15:0] st;
        logic [15:0] sw;
        logic [15:0] sh;
    } side_t;

    typedef struct packed {
        logic [15:0] ow;
        logic [15:0] oh;
        logic [15:0] x1;
        logic [15:0] y1;
    } mid_t;

    cfg_t        cfg_reg;
    logic        cfg_known;
    logic        geo_busy;
    geom_t       geo;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;
    side_t          side_reg [NST-1];
    logic [15:0]    clp_reg  [4];
    div_lane_t      lanes_reg [9][4];
    mid_t           mid_reg;
    out_word_t      out_reg;

    function automatic logic [15:0] clamp_edge(logic [31:0] v, logic [15:0] lo,
                                               logic [15:0] hi);
        logic [15:0] r;
        if (v[31] || (v < {16'd0, lo}))
            r = lo;
        else if (v > {16'd0, hi})
            r = hi;
        else
            r = v[15:0];
        return r;
    endfunction

    assign cfg_known = (cfg_index == REG_CLIENT_WIDTH) || (cfg_index == REG_CLIENT_HEIGHT)
                       || (cfg_index == REG_BACK_WIDTH) || (cfg_index == REG_BACK_HEIGHT)
                       || (cfg_index == REG_INTEGER_MODE) || (cfg_index == REG_SMOOTH_ENABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CLIENT_WIDTH:  cfg_reg.client_width  <= cfg_data & SIZE_MASK;
                REG_CLIENT_HEIGHT: cfg_reg.client_height <= cfg_data & SIZE_MASK;
                REG_BACK_WIDTH:    cfg_reg.back_width    <= cfg_data & SIZE_MASK;
                REG_BACK_HEIGHT:   cfg_reg.back_height   <= cfg_data & SIZE_MASK;
                REG_INTEGER_MODE:  cfg_reg.integer_mode  <= cfg_data[0];
                REG_SMOOTH_ENABLE: cfg_reg.smooth_enable <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    ldrm_geom #(
        .MAX_INT_SCALE(MAX_INT_SCALE)
    ) u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_write && cfg_known),
        .cfg   (cfg_reg),
        .busy  (geo_busy),
        .geo   (geo)
    );

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign in_ready  = en[0] && !geo_busy;
    assign out_valid = v_reg[NST-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid && !geo_busy;
            for (int i = 1; i < NST; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Stage 0: clamp the rectangle to the backbuffer.
    logic [15:0] l0, t0, r0, b0;
    logic [31:0] rr0, rb0;
    logic        fb0;
    side_t       side0;

    always_comb
    begin
        rr0 = (in_data.rect_right == EDGE_MARK) ? {16'd0, cfg_reg.back_width}
                                                : in_data.rect_right;
        rb0 = (in_data.rect_bottom == EDGE_MARK) ? {16'd0, cfg_reg.back_height}
                                                 : in_data.rect_bottom;
        l0  = clamp_edge(in_data.rect_left, 16'd0, cfg_reg.back_width);
        t0  = clamp_edge(in_data.rect_top, 16'd0, cfg_reg.back_height);
        r0  = clamp_edge(rr0, l0, cfg_reg.back_width);
        b0  = clamp_edge(rb0, t0, cfg_reg.back_height);
        fb0 = in_data.op && ((r0 == l0) || (b0 == t0));
        side0.full     = !in_data.op || fb0;
        side0.fallback = fb0;
        side0.sl       = l0;
        side0.st       = t0;
        side0.sw       = r0 - l0;
        side0.sh       = b0 - t0;
    end

    // Stages 1 to 9: rounded products, then two quotient bits per stage.
    logic [31:0] num1 [4];
    logic [15:0] dsor [4];

    assign dsor[0] = cfg_reg.back_width;
    assign dsor[1] = cfg_reg.back_height;
    assign dsor[2] = cfg_reg.back_width;
    assign dsor[3] = cfg_reg.back_height;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            num1[j] = 32'({16'd0, clp_reg[j]} * {16'd0, ((j % 2) == 0) ? geo.dw : geo.dh})
                      + {17'd0, dsor[j][15:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side0;
            clp_reg[0]  <= l0;
            clp_reg[1]  <= t0;
            clp_reg[2]  <= r0;
            clp_reg[3]  <= b0;
        end
        for (int i = 1; i < NST - 1; i++)
            if (en[i])
                side_reg[i] <= side_reg[i-1];
        if (en[1])
            for (int j = 0; j < 4; j++)
            begin
                lanes_reg[0][j].rem <= num1[j][31:16];
                lanes_reg[0][j].low <= num1[j][15:0];
            end
        for (int i = 2; i < 10; i++)
            if (en[i])
                for (int j = 0; j < 4; j++)
                    lanes_reg[i-1][j] <= div_step(div_step(lanes_reg[i-2][j], dsor[j]),
                                                  dsor[j]);
    end

    // Stage 10: extents and mapped start corners.
    logic [15:0] ow10, oh10;

    assign ow10 = lanes_reg[8][2].low - lanes_reg[8][0].low;
    assign oh10 = lanes_reg[8][3].low - lanes_reg[8][1].low;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            mid_reg.ow <= (ow10 == 16'd0) ? 16'd1 : ow10;
            mid_reg.oh <= (oh10 == 16'd0) ? 16'd1 : oh10;
            mid_reg.x1 <= geo.dx + lanes_reg[8][0].low;
            mid_reg.y1 <= geo.dy + lanes_reg[8][1].low;
        end
    end

    // Stage 11: keep the rectangle inside the destination and build the word.
    logic [15:0] xmax, ymax;
    out_word_t   out_next;
    side_t       s11;

    always_comb
    begin
        s11      = side_reg[NST-2];
        xmax     = geo.dx + geo.dw - mid_reg.ow;
        ymax     = geo.dy + geo.dh - mid_reg.oh;
        out_next = '0;
        if (geo.ok)
        begin
            out_next.valid_res     = 1'b1;
            out_next.fallback_full = s11.fallback;
            out_next.smooth        = geo.smooth;
            out_next.band_mask     = geo.bands;
            if (s11.full)
            begin
                out_next.dest_left   = geo.dx;
                out_next.dest_top    = geo.dy;
                out_next.dest_width  = geo.dw;
                out_next.dest_height = geo.dh;
                out_next.src_width   = cfg_reg.back_width;
                out_next.src_height  = cfg_reg.back_height;
            end
            else
            begin
                out_next.dest_left   = (mid_reg.x1 > xmax) ? xmax : mid_reg.x1;
                out_next.dest_top    = (mid_reg.y1 > ymax) ? ymax : mid_reg.y1;
                out_next.dest_width  = mid_reg.ow;
                out_next.dest_height = mid_reg.oh;
                out_next.src_left    = s11.sl;
                out_next.src_top     = s11.st;
                out_next.src_width   = s11.sw;
                out_next.src_height  = s11.sh;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
            out_reg <= out_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        geo_busy |-> !in_ready)
        else $error("word accepted while geometry is being recomputed");
    a_nonzero_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.valid_res) |->
        (out_data.dest_width != 16'd0) && (out_data.dest_height != 16'd0))
        else $error("valid result with an empty destination");
    a_fallback_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fallback_full) |-> out_data.valid_res)
        else $error("fallback raised on an invalid result");

endmodule

>>> hdl/ldrm_geom.sv
// ----------------------------------------------------------------------------
// Letterbox geometry unit
// Works out the aspect-fit destination rectangle (integer-scaled in integer mode when the client covers the
// backbuffer), offsets, band mask and smooth flag after each configuration write, using one iterative divider.
// ----------------------------------------------------------------------------
module ldrm_geom #(
    parameter int MAX_INT_SCALE = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ldrm_pkg::cfg_t cfg,
    output logic           busy,
    output ldrm_pkg::geom_t geo
);
    import ldrm_pkg::*;

    localparam logic [15:0] MAX_K = 16'(MAX_INT_SCALE);

    geo_state_t  state_reg, state_next;
    logic [31:0] prod_a_reg, prod_b_reg;
    logic        fit_w_reg, up_reg;
    div_lane_t   dv_reg;
    logic [15:0] dsor_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] qa_reg, qb_reg, k_reg;
    logic [15:0] dw_reg, dh_reg, dx_reg, dy_reg;
    logic [3:0]  band_reg;
    logic        smooth_reg;

    div_lane_t   dv_step;
    logic        fit_w;
    logic [31:0] num_a;
    logic [15:0] k_min;
    logic [31:0] dw_raw, dh_raw;

    assign dv_step = div_step(dv_reg, dsor_reg);
    assign fit_w   = prod_a_reg <= prod_b_reg;
    assign num_a   = up_reg ? {16'd0, cfg.client_width} : (fit_w ? prod_a_reg : prod_b_reg);
    assign k_min   = (qa_reg < qb_reg) ? qa_reg : qb_reg;
    assign dw_raw  = up_reg ? 32'({16'd0, cfg.back_width} * {16'd0, k_reg})
                            : (fit_w_reg ? {16'd0, cfg.client_width} : {16'd0, qa_reg});
    assign dh_raw  = up_reg ? 32'({16'd0, cfg.back_height} * {16'd0, k_reg})
                            : (fit_w_reg ? {16'd0, qa_reg} : {16'd0, cfg.client_height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= GEO_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = (state_reg != GEO_IDLE);
        case (state_reg)
            GEO_IDLE:   state_next = GEO_IDLE;
            GEO_MUL:    state_next = GEO_CMP;
            GEO_CMP:    state_next = GEO_DIV_A;
            GEO_DIV_A:  if (cnt_reg == 4'd15) state_next = GEO_DIV_B;
            GEO_DIV_B:  if (cnt_reg == 4'd15) state_next = GEO_SCALE;
            GEO_SCALE:  state_next = GEO_SIZE;
            GEO_SIZE:   state_next = GEO_OFFSET;
            GEO_OFFSET: state_next = GEO_BAND;
            GEO_BAND:   state_next = GEO_IDLE;
            default:    state_next = GEO_IDLE;
        endcase
        if (start)
            state_next = GEO_MUL;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            GEO_MUL:
            begin
                prod_a_reg <= 32'({16'd0, cfg.client_width} * {16'd0, cfg.back_height});
                prod_b_reg <= 32'({16'd0, cfg.client_height} * {16'd0, cfg.back_width});
                up_reg     <= cfg.integer_mode && (cfg.client_width >= cfg.back_width)
                              && (cfg.client_height >= cfg.back_height);
            end
            GEO_CMP:
            begin
                fit_w_reg  <= fit_w;
                dv_reg.rem <= num_a[31:16];
                dv_reg.low <= num_a[15:0];
                dsor_reg   <= (up_reg || fit_w) ? cfg.back_width : cfg.back_height;
                cnt_reg    <= 4'd0;
            end
            GEO_DIV_A:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    qa_reg     <= dv_step.low;
                    dv_reg.rem <= 16'd0;
                    dv_reg.low <= cfg.client_height;
                    dsor_reg   <= cfg.back_height;
                end
                else
                begin
                    dv_reg <= dv_step;
                end
            end
            GEO_DIV_B:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                dv_reg  <= dv_step;
                if (cnt_reg == 4'd15)
                    qb_reg <= dv_step.low;
            end
            GEO_SCALE:
            begin
                if (k_min == 16'd0)
                    k_reg <= 16'd1;
                else if (k_min > MAX_K)
                    k_reg <= MAX_K;
                else
                    k_reg <= k_min;
            end
            GEO_SIZE:
            begin
                if (dw_raw == 32'd0)
                    dw_reg <= 16'd1;
                else if (dw_raw > {16'd0, cfg.client_width})
                    dw_reg <= cfg.client_width;
                else
                    dw_reg <= dw_raw[15:0];
                if (dh_raw == 32'd0)
                    dh_reg <= 16'd1;
                else if (dh_raw > {16'd0, cfg.client_height})
                    dh_reg <= cfg.client_height;
                else
                    dh_reg <= dh_raw[15:0];
            end
            GEO_OFFSET:
            begin
                dx_reg <= 16'((cfg.client_width - dw_reg) >> 1);
                dy_reg <= 16'((cfg.client_height - dh_reg) >> 1);
            end
            GEO_BAND:
            begin
                band_reg[0] <= dy_reg != 16'd0;
                band_reg[1] <= dx_reg != 16'd0;
                band_reg[2] <= ({1'b0, dx_reg} + {1'b0, dw_reg}) < {1'b0, cfg.client_width};
                band_reg[3] <= ({1'b0, dy_reg} + {1'b0, dh_reg}) < {1'b0, cfg.client_height};
                smooth_reg  <= cfg.smooth_enable && (!cfg.integer_mode
                               || (cfg.client_width < cfg.back_width)
                               || (cfg.client_height < cfg.back_height));
            end
            default:
            begin
            end
        endcase
    end

    assign geo.ok     = (cfg.client_width != 16'd0) && (cfg.client_height != 16'd0)
                        && (cfg.back_width != 16'd0) && (cfg.back_height != 16'd0);
    assign geo.dw     = dw_reg;
    assign geo.dh     = dh_reg;
    assign geo.dx     = dx_reg;
    assign geo.dy     = dy_reg;
    assign geo.bands  = band_reg;
    assign geo.smooth = smooth_reg;

    a_div_count_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == GEO_CMP) |=> (cnt_reg == 4'd0))
        else $error("divider count not cleared on load");
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == GEO_MUL))
        else $error("geometry did not restart after a write");
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == GEO_IDLE && !start) |=> $stable(dw_reg) && $stable(dh_reg))
        else $error("geometry changed while idle");

endmodule
